// ===== rtl/ordered_key_value_encoder_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ORDERED_KEY_VALUE_ENCODER_UNIT_MACROS_SVH
`define ORDERED_KEY_VALUE_ENCODER_UNIT_MACROS_SVH

// Property sampled on the rising clock, off while in reset.
`define OKVE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("okve assertion failed");

// Property checked during reset as well.
`define OKVE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("okve reset assertion failed");

`endif

// ===== rtl/okve_pkg.sv =====
// Shared types, codes and constants of the ordered key encoder.
`default_nettype none

package okve_pkg;

  localparam logic [3:0] ACT_INT          = 4'd0;
  localparam logic [3:0] ACT_FINGERPRINT  = 4'd1;
  localparam logic [3:0] ACT_TIME         = 4'd2;
  localparam logic [3:0] ACT_BOOL         = 4'd3;
  localparam logic [3:0] ACT_BYTES_OPEN   = 4'd4;
  localparam logic [3:0] ACT_BYTES_DATA   = 4'd5;
  localparam logic [3:0] ACT_BYTES_CLOSE  = 4'd6;
  localparam logic [3:0] ACT_STRING_OPEN  = 4'd7;
  localparam logic [3:0] ACT_STRING_CHAR  = 4'd8;
  localparam logic [3:0] ACT_STRING_CLOSE = 4'd9;

  localparam logic [2:0] REG_INT_POS     = 3'd0;
  localparam logic [2:0] REG_INT_NEG     = 3'd1;
  localparam logic [2:0] REG_FINGERPRINT = 3'd2;
  localparam logic [2:0] REG_TIME        = 3'd3;
  localparam logic [2:0] REG_BOOL        = 3'd4;
  localparam logic [2:0] REG_BYTES       = 3'd5;
  localparam logic [2:0] REG_STRING      = 3'd6;
  localparam logic [2:0] REG_TERMINATOR  = 3'd7;

  localparam logic [7:0] RST_INT_POS     = 8'd48;
  localparam logic [7:0] RST_INT_NEG     = 8'd40;
  localparam logic [7:0] RST_FINGERPRINT = 8'd64;
  localparam logic [7:0] RST_TIME        = 8'd80;
  localparam logic [7:0] RST_BOOL        = 8'd16;
  localparam logic [7:0] RST_BYTES       = 8'd96;
  localparam logic [7:0] RST_STRING      = 8'd112;
  localparam logic [7:0] RST_TERMINATOR  = 8'd0;

  localparam logic [7:0] CLOSE_BYTE = 8'd0;

  // Depth of the descriptor queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] int_pos_tag;
    logic [7:0] int_neg_tag;
    logic [7:0] fingerprint_tag;
    logic [7:0] time_tag;
    logic [7:0] bool_tag;
    logic [7:0] bytes_tag;
    logic [7:0] string_tag;
    logic [7:0] terminator_byte;
  } cfg_t;

  // One item's work: a leading byte, then cnt bytes of payload, high byte first.
  typedef struct packed {
    logic [7:0]  head;
    logic [3:0]  cnt;
    logic [63:0] payload;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/okve_fifo.sv =====
// Short descriptor queue between the front and back parts.
`default_nettype none

module okve_fifo
  import okve_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  desc_t wdata_i,
  input  logic  rd_i,
  output desc_t rdata_o,
  output logic  full_o,
  output logic  empty_o
);

  desc_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/okve_front.sv =====
// Front part: classifies a request and builds its output descriptor.
`default_nettype none

module okve_front
  import okve_pkg::*;
(
  input  logic [3:0]  action_i,
  input  logic [63:0] value_i,
  input  cfg_t        cfg_i,
  output desc_t       desc_o,
  output logic        keep_o
);

  // Bytes needed for a magnitude; seven-byte values take eight.
  function automatic logic [3:0] size_of(input logic [63:0] m);
    logic [3:0] n;
    if (m[63:8] == '0)       n = 4'd1;
    else if (m[63:16] == '0) n = 4'd2;
    else if (m[63:24] == '0) n = 4'd3;
    else if (m[63:32] == '0) n = 4'd4;
    else if (m[63:40] == '0) n = 4'd5;
    else if (m[63:48] == '0) n = 4'd6;
    else                     n = 4'd8;
    return n;
  endfunction

  logic        neg;
  logic [63:0] mag;
  logic [3:0]  n;
  logic [7:0]  n_m1;
  logic [7:0]  pos_base;
  logic [7:0]  lo;

  assign neg  = (action_i == ACT_INT) && value_i[63];
  assign mag  = neg ? ~value_i : value_i;
  assign n    = size_of(mag);
  assign n_m1 = {4'd0, n - 4'd1};
  assign lo   = value_i[7:0];

  always_comb begin
    case (action_i)
      ACT_FINGERPRINT: pos_base = cfg_i.fingerprint_tag;
      ACT_TIME:        pos_base = cfg_i.time_tag;
      default:         pos_base = cfg_i.int_pos_tag;
    endcase
  end

  always_comb begin
    keep_o         = 1'b1;
    desc_o.head    = lo;
    desc_o.cnt     = 4'd0;
    desc_o.payload = value_i;
    unique case (action_i) inside
      ACT_INT, ACT_FINGERPRINT, ACT_TIME: begin
        desc_o.head = neg ? cfg_i.int_neg_tag - n_m1 : pos_base + n_m1;
        desc_o.cnt  = n;
      end
      ACT_BOOL: begin
        desc_o.head = cfg_i.bool_tag + {7'd0, value_i[0]};
      end
      ACT_BYTES_OPEN: begin
        desc_o.head = cfg_i.bytes_tag;
      end
      ACT_BYTES_DATA: begin
        // terminator value in data is escaped by doubling
        desc_o.payload = {56'd0, lo};
        desc_o.cnt     = (lo == cfg_i.terminator_byte) ? 4'd1 : 4'd0;
      end
      ACT_BYTES_CLOSE: begin
        desc_o.head    = cfg_i.terminator_byte;
        desc_o.payload = {56'd0, CLOSE_BYTE};
        desc_o.cnt     = 4'd1;
      end
      ACT_STRING_OPEN: begin
        desc_o.head = cfg_i.string_tag;
      end
      ACT_STRING_CHAR: begin
        desc_o.head = lo;
      end
      ACT_STRING_CLOSE: begin
        desc_o.head = CLOSE_BYTE;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/okve_back.sv =====
// Back part: walks a descriptor and emits one byte per cycle into the output register while it is free or popped.
`default_nettype none

module okve_back
  import okve_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_t      desc_i,
  input  logic       desc_empty_i,
  output logic       desc_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic        active_q, active_d;
  logic [3:0]  rem_q, rem_d;
  logic [63:0] payload_q, payload_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        load;
  logic [2:0]  idx;

  assign load = !valid_q || pop_i;
  // rem counts 1..8; byte rem-1 is next, the 3-bit wrap maps 8 onto index 7
  assign idx  = rem_q[2:0] - 3'd1;

  assign desc_pop_o = load && !active_q && !desc_empty_i;

  always_comb begin
    active_d  = active_q;
    rem_d     = rem_q;
    payload_d = payload_q;
    valid_d   = valid_q;
    byte_d    = byte_q;
    last_d    = last_q;
    if (load) begin
      if (active_q) begin
        valid_d  = 1'b1;
        byte_d   = payload_q[{idx, 3'b000} +: 8];
        last_d   = (rem_q == 4'd1);
        rem_d    = rem_q - 4'd1;
        active_d = (rem_q != 4'd1);
      end else if (!desc_empty_i) begin
        valid_d   = 1'b1;
        byte_d    = desc_i.head;
        last_d    = (desc_i.cnt == 4'd0);
        rem_d     = desc_i.cnt;
        payload_d = desc_i.payload;
        active_d  = (desc_i.cnt != 4'd0);
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rem_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      rem_q    <= rem_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
  end

  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// ===== rtl/ordered_key_value_encoder_unit.sv =====
// Path: an accepted request is written into the descriptor queue, then its first byte into the output register.
// Throughput: one result byte per cycle while the output is popped; a request of n bytes holds the
// back end until its n bytes are out, and single-byte requests are taken every cycle, paced by the byte emitter.
// A two-entry descriptor queue and the output register let input and output stall separately.
// Reset: asynchronous; control and config registers return to their defaults, queue and output go empty.
`default_nettype none

module ordered_key_value_encoder_unit
  import okve_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  action_i,
  input  logic [63:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q, cfg_d;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic [7:0] rd_byte;

  desc_t desc_in, desc_out;
  logic  keep;
  logic  q_wr, q_rd, q_full, q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_INT_POS:     cfg_d.int_pos_tag     = pwdata[7:0];
        REG_INT_NEG:     cfg_d.int_neg_tag     = pwdata[7:0];
        REG_FINGERPRINT: cfg_d.fingerprint_tag = pwdata[7:0];
        REG_TIME:        cfg_d.time_tag        = pwdata[7:0];
        REG_BOOL:        cfg_d.bool_tag        = pwdata[7:0];
        REG_BYTES:       cfg_d.bytes_tag       = pwdata[7:0];
        REG_STRING:      cfg_d.string_tag      = pwdata[7:0];
        REG_TERMINATOR:  cfg_d.terminator_byte = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INT_POS:     rd_byte = cfg_q.int_pos_tag;
      REG_INT_NEG:     rd_byte = cfg_q.int_neg_tag;
      REG_FINGERPRINT: rd_byte = cfg_q.fingerprint_tag;
      REG_TIME:        rd_byte = cfg_q.time_tag;
      REG_BOOL:        rd_byte = cfg_q.bool_tag;
      REG_BYTES:       rd_byte = cfg_q.bytes_tag;
      REG_STRING:      rd_byte = cfg_q.string_tag;
      REG_TERMINATOR:  rd_byte = cfg_q.terminator_byte;
      default:         rd_byte = '0;
    endcase
  end

  assign prdata = {24'd0, rd_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_pos_tag     <= RST_INT_POS;
      cfg_q.int_neg_tag     <= RST_INT_NEG;
      cfg_q.fingerprint_tag <= RST_FINGERPRINT;
      cfg_q.time_tag        <= RST_TIME;
      cfg_q.bool_tag        <= RST_BOOL;
      cfg_q.bytes_tag       <= RST_BYTES;
      cfg_q.string_tag      <= RST_STRING;
      cfg_q.terminator_byte <= RST_TERMINATOR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  okve_front u_front (
    .action_i (action_i),
    .value_i  (value_i),
    .cfg_i    (cfg_q),
    .desc_o   (desc_in),
    .keep_o   (keep)
  );

  // unknown actions are accepted and dropped here
  assign full = q_full;
  assign q_wr = push && !q_full && keep;

  okve_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (desc_in),
    .rd_i    (q_rd),
    .rdata_o (desc_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  okve_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc_out),
    .desc_empty_i (q_empty),
    .desc_pop_o   (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/okve_checker.sv =====
// Port-level checker for the encoder top level, with its bind.
`default_nettype none
`include "ordered_key_value_encoder_unit_macros.svh"

module okve_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte_o,
  input logic        last_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic [8:0] out_word;
  logic       wr_req;
  logic [2:0] wr_idx_q;
  logic [7:0] wr_byte_q;
  logic       rb_ok;

  assign out_word = {out_byte_o, last_o};
  assign wr_req   = psel && penable && pwrite && pready;

  // last register write, for the read-back check
  always_ff @(posedge clk_i) begin
    if (wr_req) begin
      wr_idx_q  <= paddr[4:2];
      wr_byte_q <= pwdata[7:0];
    end
  end

  assign rb_ok = !psel || pwrite || (paddr[4:2] != wr_idx_q) ||
                 (prdata == {24'd0, wr_byte_q});

  // a waiting result holds until taken
  `OKVE_ASSERT(a_out_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_word)))

  // queue cannot fill while the output register has gone dry
  `OKVE_ASSERT(a_empty_not_full, clk_i, rst_ni, empty |-> !full)

  // reading back the register just written returns its low byte
  `OKVE_ASSERT(a_cfg_readback, clk_i, rst_ni, wr_req |=> rb_ok)

  `OKVE_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> (empty && !full))

endmodule

bind ordered_key_value_encoder_unit okve_checker u_okve_checker (.*);

`default_nettype wire
